// ===== rtl/core/positional_list_engine_core_macros.svh =====
// ----------------------------------------------------------------------------
// positional list engine core assertion macros
// clocked checks on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold at every edge
`define PLE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define PLE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PLE_ASSERT_ALWAYS(lbl, expr, msg)
`define PLE_ASSERT_IMPL(lbl, ante, cons, msg)
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and codes of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int CNT_OUT_W = 7;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]              mode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_OUT_W-1:0]    entry_count;
        logic [1:0]              status;
    } res_t;

    typedef struct packed {
        status_t status;
        logic    op_ok;
        logic    no_shift;
    } chk_t;

endpackage

// ===== rtl/core/ple_store.sv =====
// ----------------------------------------------------------------------------
// ple_store
// entry memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module ple_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [AW-1:0]                   waddr,
    input  logic signed [ple_pkg::VAL_W-1:0] wdata,
    input  logic                            re,
    input  logic [AW-1:0]                   raddr,
    output logic signed [ple_pkg::VAL_W-1:0] rdata
);

    logic signed [ple_pkg::VAL_W-1:0] mem_reg [DEPTH];
    logic signed [ple_pkg::VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ple_check.sv =====
// ----------------------------------------------------------------------------
// ple_check
// request validation against the current entry count
// ----------------------------------------------------------------------------
module ple_check #(
    parameter int CAPACITY = 64,
    parameter int CW       = 7
) (
    input  ple_pkg::req_t   req,
    input  logic [CW-1:0]   count,
    output ple_pkg::chk_t   chk
);

    localparam int CMPW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] cap_x;

    assign pos_x = CMPW'(req.position);
    assign cnt_x = CMPW'(count);
    assign cap_x = CMPW'(CAPACITY);

    always_comb
    begin
        chk.status   = ple_pkg::ST_BADPOS;
        chk.op_ok    = 1'b0;
        chk.no_shift = 1'b0;
        unique case (req.mode)
            ple_pkg::MODE_INSERT:
            begin
                if (pos_x > cnt_x)
                begin
                    chk.status = ple_pkg::ST_BADPOS;
                end
                else if (cnt_x >= cap_x)
                begin
                    chk.status = ple_pkg::ST_FULL;
                end
                else
                begin
                    chk.status   = ple_pkg::ST_OK;
                    chk.op_ok    = 1'b1;
                    chk.no_shift = (pos_x == cnt_x);
                end
            end
            ple_pkg::MODE_DELETE:
            begin
                if (pos_x < cnt_x)
                begin
                    chk.status   = ple_pkg::ST_OK;
                    chk.op_ok    = 1'b1;
                    chk.no_shift = ((pos_x + CMPW'(1)) == cnt_x);
                end
            end
            ple_pkg::MODE_READ:
            begin
                if (pos_x < cnt_x)
                begin
                    chk.status   = ple_pkg::ST_OK;
                    chk.op_ok    = 1'b1;
                    chk.no_shift = 1'b1;
                end
            end
            default:
            begin
                chk.status = ple_pkg::ST_BADPOS;
            end
        endcase
    end

endmodule

// ===== rtl/core/ple_seq.sv =====
// ----------------------------------------------------------------------------
// ple_seq
// request sequencer: entry count, shift walk through memory, result register
// ----------------------------------------------------------------------------
module ple_seq #(
    parameter int CW = 7,
    parameter int AW = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  ple_pkg::req_t                    req,
    input  ple_pkg::chk_t                    chk,
    output logic [CW-1:0]                    count,
    output logic                             busy,
    output logic                             done,
    output ple_pkg::res_t                    res,
    output logic                             mem_we,
    output logic [AW-1:0]                    mem_waddr,
    output logic signed [ple_pkg::VAL_W-1:0] mem_wdata,
    output logic                             mem_re,
    output logic [AW-1:0]                    mem_raddr,
    input  logic signed [ple_pkg::VAL_W-1:0] mem_rdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } seq_state_t;

    seq_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic done_reg, done_next;
    ple_pkg::res_t res_reg, res_next;
    logic [1:0] mode_reg, mode_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] ra_reg, ra_next;
    logic signed [ple_pkg::VAL_W-1:0] value_reg, value_next;

    logic is_ins;
    logic last_move;
    logic [1:0] res_status;
    logic signed [ple_pkg::VAL_W-1:0] res_value;

    assign is_ins = (mode_reg == ple_pkg::MODE_INSERT);
    assign last_move = is_ins ? (ra_reg == pos_reg)
                              : ((CW'(ra_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        ra_next    = ra_reg;
        value_next = value_reg;
        done_next  = 1'b0;
        res_status = ple_pkg::ST_OK;
        res_value  = '0;
        mem_we     = 1'b0;
        mem_waddr  = pos_reg;
        mem_wdata  = value_reg;
        mem_re     = 1'b0;
        mem_raddr  = ra_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = req.mode;
                    pos_next   = AW'(req.position);
                    value_next = req.value;
                    priority if (!chk.op_ok)
                    begin
                        done_next  = 1'b1;
                        res_status = chk.status;
                    end
                    else if (req.mode == ple_pkg::MODE_READ)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(req.position);
                        state_next = S_READ;
                    end
                    else if (req.mode == ple_pkg::MODE_INSERT && chk.no_shift)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = AW'(req.position);
                        mem_wdata  = req.value;
                        count_next = count_reg + CW'(1);
                        done_next  = 1'b1;
                    end
                    else if (req.mode == ple_pkg::MODE_INSERT)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(count_reg - CW'(1));
                        ra_next    = AW'(count_reg - CW'(1));
                        state_next = S_SHIFT;
                    end
                    else if (chk.no_shift)
                    begin
                        count_next = count_reg - CW'(1);
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(req.position) + AW'(1);
                        ra_next    = AW'(req.position) + AW'(1);
                        state_next = S_SHIFT;
                    end
                end
            end
            S_READ:
            begin
                res_value  = mem_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                mem_waddr = is_ins ? (ra_reg + AW'(1)) : (ra_reg - AW'(1));
                if (last_move)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = is_ins ? (ra_reg - AW'(1)) : (ra_reg + AW'(1));
                    ra_next   = mem_raddr;
                end
            end
            S_FINISH:
            begin
                if (is_ins)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg;
                    mem_wdata  = value_reg;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_next             = res_reg;
        if (done_next)
        begin
            res_next.read_value  = res_value;
            res_next.entry_count = ple_pkg::CNT_OUT_W'(count_next);
            res_next.status      = res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        mode_reg  <= mode_next;
        pos_reg   <= pos_next;
        ra_reg    <= ra_next;
        value_reg <= value_next;
    end

    assign count = count_reg;
    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign res   = res_reg;

endmodule

// ===== rtl/core/positional_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_core
// bounded ordered list of signed words with insert, delete and read by position
// ----------------------------------------------------------------------------
// usage:
//   a request word (req) is taken at a clock edge where start is high and busy
//   is low. each request gives exactly one result word on res, shown for one
//   cycle with done high; the receiver cannot hold it off.
// sequence, from the accepting edge to the done cycle:
//   rejected request, insert at the tail, delete of the last entry: done is
//   shown in the cycle after; read: state S_READ (one synchronous memory read)
//   insert or delete at p: S_SHIFT walks the entries behind p, then S_FINISH
//   the shift walk moves one entry per cycle through the single memory
//   (read one place, write its neighbour).
// throughput: one request at a time; busy is high while the walk runs and a
//   new request may be taken in the same cycle that done is shown.
// reset: the list is empty; memory contents are left as they are and are
//   never read before being written.
// ----------------------------------------------------------------------------
`include "positional_list_engine_core_macros.svh"

module positional_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ple_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output ple_pkg::res_t res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic [CW-1:0] count;
    ple_pkg::chk_t chk;
    logic mem_we;
    logic mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic signed [ple_pkg::VAL_W-1:0] mem_wdata;
    logic signed [ple_pkg::VAL_W-1:0] mem_rdata;

    ple_check #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_check (
        .req   (req),
        .count (count),
        .chk   (chk)
    );

    ple_seq #(
        .CW (CW),
        .AW (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .chk       (chk),
        .count     (count),
        .busy      (busy),
        .done      (done),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ple_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // no read and write of the same entry in one cycle
    `PLE_ASSERT_ALWAYS(a_no_rw_clash, !(mem_we && mem_re && (mem_waddr == mem_raddr)), "memory read and write collide")
    `PLE_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted word made no progress")
    `PLE_ASSERT_IMPL(a_reject_zero, done && (res.status != ple_pkg::ST_OK), res.read_value == '0, "rejected word carries data")
    `PLE_ASSERT_IMPL(a_full_count, done && (res.status == ple_pkg::ST_FULL), res.entry_count == ple_pkg::CNT_OUT_W'(CAPACITY), "full status with list not full")

endmodule
